/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks on clocked logic with an active low
// reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A cause in one cycle that must be followed by an effect in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

/* rtl/tmwf_pkg.sv */
// ----------------------------------------------------------------------------
// Trimmed mean window filter package
// Shared widths, defaults, state encoding and control structures.
// ----------------------------------------------------------------------------
package tmwf_pkg;

	localparam int DATA_W          = 16;
	localparam int WINDOW_SIZE_DEF = 10;
	localparam int TRIM_EACH_END   = 2;

	localparam logic signed [DATA_W-1:0] SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_CALC,
		ST_OUT
	} tmwf_state_t;

	// Control for the order statistics accumulator.
	typedef struct packed {
		logic clear;
		logic en;
	} acc_ctl_t;

endpackage

/* rtl/tmwf_window_ram.sv */
// ----------------------------------------------------------------------------
// Window sample memory
// Single write port, one registered read port. Entries not written since the
// last level write read back as the current initial level.
// ----------------------------------------------------------------------------
module tmwf_window_ram
	import tmwf_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	parameter int IDX_W       = $clog2(WINDOW_SIZE)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     level_we,
	input  logic signed [DATA_W-1:0] level,
	input  logic                     we,
	input  logic [IDX_W-1:0]         waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic                     re,
	input  logic [IDX_W-1:0]         raddr,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]   vld_q;
	logic signed [DATA_W-1:0] level_q;
	logic signed [DATA_W-1:0] rdata_s1;
	logic                     rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
			rvld_s1  <= vld_q[raddr];
		end
	end

	// A level write invalidates every slot at once instead of sweeping the array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			level_q <= '0;
		end else if (level_we) begin
			vld_q   <= '0;
			level_q <= level;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : level_q;

endmodule

/* rtl/tmwf_order_stats.sv */
// ----------------------------------------------------------------------------
// Order statistics accumulator
// Takes one window entry per cycle while enabled and keeps the running total
// together with the two smallest and two largest values seen.
// ----------------------------------------------------------------------------
module tmwf_order_stats
	import tmwf_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	parameter int ACC_W       = DATA_W + $clog2(WINDOW_SIZE) + 1
) (
	input  logic                     clk,
	input  acc_ctl_t                 ctl,
	input  logic signed [DATA_W-1:0] value,
	output logic signed [ACC_W-1:0]  total,
	output logic signed [DATA_W-1:0] lo1,
	output logic signed [DATA_W-1:0] lo2,
	output logic signed [DATA_W-1:0] hi1,
	output logic signed [DATA_W-1:0] hi2
);

	logic signed [ACC_W-1:0]  total_q;
	logic signed [DATA_W-1:0] lo1_q, lo2_q, hi1_q, hi2_q;

	// lo1 <= lo2 and hi1 >= hi2 always; equal values count separately.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			total_q <= '0;
			lo1_q   <= SAMPLE_MAX;
			lo2_q   <= SAMPLE_MAX;
			hi1_q   <= SAMPLE_MIN;
			hi2_q   <= SAMPLE_MIN;
		end else if (ctl.en) begin
			total_q <= total_q + ACC_W'(value);
			if (value < lo1_q) begin
				lo2_q <= lo1_q;
				lo1_q <= value;
			end else if (value < lo2_q) begin
				lo2_q <= value;
			end
			if (value > hi1_q) begin
				hi2_q <= hi1_q;
				hi1_q <= value;
			end else if (value > hi2_q) begin
				hi2_q <= value;
			end
		end
	end

	assign total = total_q;
	assign lo1   = lo1_q;
	assign lo2   = lo2_q;
	assign hi1   = hi1_q;
	assign hi2   = hi2_q;

endmodule

/* rtl/tmwf_mean_div.sv */
// ----------------------------------------------------------------------------
// Trimmed mean divider
// Forms the rounded trimmed sum and divides it by the kept count with a
// reciprocal multiply, one correction step and truncation toward zero.
// ----------------------------------------------------------------------------
module tmwf_mean_div
	import tmwf_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	parameter int ACC_W       = DATA_W + $clog2(WINDOW_SIZE) + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [ACC_W-1:0]  total,
	input  logic signed [DATA_W-1:0] lo1,
	input  logic signed [DATA_W-1:0] lo2,
	input  logic signed [DATA_W-1:0] hi1,
	input  logic signed [DATA_W-1:0] hi2,
	output logic                     done,
	output logic signed [DATA_W-1:0] quot
);

	localparam int KEPT  = WINDOW_SIZE - 2 * TRIM_EACH_END;
	localparam int SHIFT = ACC_W;
	localparam longint unsigned RECIP_FULL = (64'd1 << SHIFT) / KEPT;
	localparam logic [SHIFT:0]     RECIP = (SHIFT+1)'(RECIP_FULL);
	localparam logic [ACC_W-1:0]   KC    = ACC_W'(KEPT);
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(KEPT / 2);

	logic signed [ACC_W-1:0]  x_s1;
	logic [ACC_W-1:0]         a_s2, a_s3, a_s4;
	logic                     neg_s2, neg_s3, neg_s4, neg_s5;
	logic [2*ACC_W:0]         prod_s3;
	logic [ACC_W-1:0]         q0_s4, q0_s5, r_s5;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ACC_W-1:0]         q_fix;
	logic signed [DATA_W-1:0] quot_q;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	// The quotient estimate is at most one short, so a single compare fixes it.
	assign q_fix = (r_s5 >= KC) ? q0_s5 + 1'b1 : q0_s5;

	always_ff @(posedge clk) begin
		x_s1    <= total - ACC_W'(lo1) - ACC_W'(lo2) - ACC_W'(hi1) - ACC_W'(hi2) + HALF;
		neg_s2  <= x_s1[ACC_W-1];
		a_s2    <= x_s1[ACC_W-1] ? ACC_W'(-x_s1) : ACC_W'(x_s1);
		prod_s3 <= (2*ACC_W+1)'(a_s2) * (2*ACC_W+1)'(RECIP);
		a_s3    <= a_s2;
		neg_s3  <= neg_s2;
		q0_s4   <= prod_s3[SHIFT +: ACC_W];
		a_s4    <= a_s3;
		neg_s4  <= neg_s3;
		q0_s5   <= q0_s4;
		r_s5    <= a_s4 - q0_s4 * KC;
		neg_s5  <= neg_s4;
		if (v_s5) begin
			quot_q <= neg_s5 ? -DATA_W'(q_fix) : DATA_W'(q_fix);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* rtl/trimmed_mean_window_filter.sv */
// Each accepted sample starts a pass that reads every window entry from the
// memory port, followed by the divider pipeline and the output load; the next
// sample is taken only after that load, so a waiting result holds off the next
// input. Reset: asynchronous, active low; the window reads as all zero
// afterwards. A level write needs no clearing pass.
// ----------------------------------------------------------------------------
// Trimmed mean window filter
// Circular sample window in memory, a sequential order statistics pass per
// sample and a pipelined division by the kept count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trimmed_mean_window_filter
	import tmwf_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic signed [DATA_W-1:0] initial_level,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] filtered
);

	localparam int IDX_W = $clog2(WINDOW_SIZE);
	localparam int ACC_W = DATA_W + $clog2(WINDOW_SIZE) + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

	tmwf_state_t state_q, state_d;

	logic [IDX_W-1:0]         wp_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic                     rd_vld_s1;
	logic                     start_s1;
	logic                     mem_re;
	logic                     load_out;
	logic                     in_fire;
	acc_ctl_t                 acc_ctl;
	logic signed [DATA_W-1:0] rd_data;
	logic signed [ACC_W-1:0]  total;
	logic signed [DATA_W-1:0] lo1, lo2, hi1, hi2;
	logic                     div_done;
	logic signed [DATA_W-1:0] quot;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] filtered_q;
	logic                     out_free;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		mem_re      = 1'b0;
		load_out    = 1'b0;
		acc_ctl     = '0;
		acc_ctl.en  = rd_vld_s1;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				acc_ctl.clear = in_valid;
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_re = 1'b1;
				if (rd_idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				if (div_done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			start_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			start_s1  <= (state_q == ST_DRAIN);
			if (cfg_we) begin
				wp_q <= '0;
			end else if (in_fire) begin
				wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
			end
			if (mem_re) begin
				rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filtered_q <= quot;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	tmwf_window_ram #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.IDX_W      (IDX_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.level_we(cfg_we),
		.level   (initial_level),
		.we      (in_fire),
		.waddr   (wp_q),
		.wdata   (sample),
		.re      (mem_re),
		.raddr   (rd_idx_q),
		.rdata   (rd_data)
	);

	tmwf_order_stats #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.ACC_W      (ACC_W)
	) u_stats (
		.clk  (clk),
		.ctl  (acc_ctl),
		.value(rd_data),
		.total(total),
		.lo1  (lo1),
		.lo2  (lo2),
		.hi1  (hi1),
		.hi2  (hi2)
	);

	tmwf_mean_div #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.ACC_W      (ACC_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_s1),
		.total (total),
		.lo1   (lo1),
		.lo2   (lo2),
		.hi1   (hi1),
		.hi2   (hi2),
		.done  (div_done),
		.quot  (quot)
	);

	// The read pass never overlaps a sample write, so no forwarding is needed.
	`ASSERT_ALWAYS(a_no_rw_overlap, clk, arst_n, !(in_fire && mem_re), "read during write")
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_fire, !in_ready && state_q == ST_READ, "not busy after accept")
	`ASSERT_ALWAYS(a_done_in_calc, clk, arst_n, !div_done || state_q == ST_CALC, "divider result outside calc")
	`ASSERT_NEXT(a_read_pass_len, clk, arst_n, mem_re && rd_idx_q == LAST_IDX, state_q == ST_DRAIN && rd_idx_q == '0, "read pass length")

endmodule

/* sim/trimmed_mean_window_filter_tb.sv */
// ----------------------------------------------------------------------------
// Trimmed mean window filter testbench
// A directed table of level writes and samples is run first, then randomized
// phases, each opened by a new initial level. Every filtered result is
// compared with the table's known result or a model of the sliding window.
// Both handshakes idle in random bursts, none in the last stretch of the run.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_tb;
	import tmwf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN          = WINDOW_SIZE_DEF;
	localparam int KEPT         = WIN - 2 * TRIM_EACH_END;
	localparam int SETTLE       = WIN + 9 + 8;
	localparam int ITEM_GOAL    = 650;
	localparam int QUIET_TAIL   = 80;
	localparam int STALL_LIMIT  = 2000;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic {
		ROW_LEVEL,
		ROW_SAMPLE
	} row_kind_t;

	typedef enum int {
		MODE_ANY,
		MODE_NEAR,
		MODE_RAIL,
		MODE_SMALL
	} sample_mode_t;

	typedef struct {
		row_kind_t kind;
		word_t     value;
		bit        known;
		word_t     result;
	} dir_row_t;

	typedef struct {
		word_t value;
		int    seq;
	} filt_exp_t;

	localparam int DIR_ROWS = 25;

	// A known result is given only where the trimmed window is plainly uniform.
	dir_row_t dir_table [DIR_ROWS] = '{
		'{ROW_SAMPLE, 16'sd0,      1'b1, 16'sd0},
		'{ROW_SAMPLE, SAMPLE_MAX,  1'b1, 16'sd0},
		'{ROW_SAMPLE, SAMPLE_MIN,  1'b1, 16'sd0},
		'{ROW_LEVEL,  SAMPLE_MAX,  1'b0, 16'sd0},
		'{ROW_SAMPLE, SAMPLE_MAX,  1'b1, SAMPLE_MAX},
		'{ROW_SAMPLE, SAMPLE_MIN,  1'b1, SAMPLE_MAX},
		'{ROW_SAMPLE, 16'sd0,      1'b0, 16'sd0},
		'{ROW_LEVEL,  SAMPLE_MIN,  1'b0, 16'sd0},
		'{ROW_SAMPLE, SAMPLE_MIN,  1'b0, 16'sd0},
		'{ROW_SAMPLE, SAMPLE_MAX,  1'b0, 16'sd0},
		'{ROW_LEVEL,  -16'sd1,     1'b0, 16'sd0},
		'{ROW_SAMPLE, -16'sd1,     1'b0, 16'sd0},
		'{ROW_SAMPLE, -16'sd4,     1'b0, 16'sd0},
		'{ROW_LEVEL,  16'sd0,      1'b0, 16'sd0},
		'{ROW_SAMPLE, 16'sd100,    1'b0, 16'sd0},
		'{ROW_SAMPLE, -16'sd100,   1'b0, 16'sd0},
		'{ROW_SAMPLE, SAMPLE_MAX,  1'b0, 16'sd0},
		'{ROW_SAMPLE, SAMPLE_MIN,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 16'sd1,      1'b0, 16'sd0},
		'{ROW_SAMPLE, 16'sd2,      1'b0, 16'sd0},
		'{ROW_SAMPLE, 16'sd3,      1'b0, 16'sd0},
		'{ROW_SAMPLE, 16'sd7,      1'b0, 16'sd0},
		'{ROW_SAMPLE, -16'sd7,     1'b0, 16'sd0},
		'{ROW_SAMPLE, 16'sd12345,  1'b0, 16'sd0},
		'{ROW_SAMPLE, -16'sd21846, 1'b0, 16'sd0}
	};

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	word_t initial_level;
	logic  in_valid;
	logic  in_ready;
	word_t sample;
	logic  out_valid;
	logic  out_ready;
	word_t filtered;

	word_t       win_model [WIN];
	int unsigned win_pos;

	filt_exp_t filt_q [$];
	filt_exp_t head;

	bit quiet;
	int items_sent;
	int levels_written;
	int results_seen;
	int mismatches;
	int stall_cycles;

	trimmed_mean_window_filter #(
		.WINDOW_SIZE(WIN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.initial_level(initial_level),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.filtered     (filtered)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void fill_model(word_t lvl);
		for (int i = 0; i < WIN; i++) begin
			win_model[i] = lvl;
		end
		win_pos = 0;
	endfunction

	// Store the sample, then average the middle of the sorted window.
	function automatic word_t push_and_average(word_t s);
		word_t ord [WIN];
		word_t key;
		int    j;
		int    acc;
		int    q;
		if (win_pos >= WIN) begin
			win_pos = 0;
		end
		win_model[win_pos] = s;
		win_pos++;
		if (win_pos >= WIN) begin
			win_pos = 0;
		end
		ord = win_model;
		for (int i = 1; i < WIN; i++) begin
			key = ord[i];
			j = i;
			while (j > 0 && ord[j-1] > key) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = key;
		end
		acc = 0;
		for (int i = TRIM_EACH_END; i < WIN - TRIM_EACH_END; i++) begin
			acc += ord[i];
		end
		// Integer division truncates toward zero, so negative sums round unevenly.
		q = (acc + KEPT / 2) / KEPT;
		return q[DATA_W-1:0];
	endfunction

	function automatic word_t pick_sample(sample_mode_t mode, word_t lvl);
		int v;
		case (mode)
			MODE_NEAR: begin
				v = int'(lvl) + int'($urandom_range(0, 600)) - 300;
			end
			MODE_RAIL: begin
				case ($urandom_range(0, 3))
					0: v = int'(SAMPLE_MIN);
					1: v = int'(SAMPLE_MAX);
					2: v = 0;
					default: v = -1;
				endcase
			end
			MODE_SMALL: begin
				v = int'($urandom_range(0, 64)) - 32;
			end
			default: begin
				v = int'($urandom_range(0, 16'hFFFF));
			end
		endcase
		return v[DATA_W-1:0];
	endfunction

	// Called at a clock edge; returns at the edge that accepts the transaction.
	task automatic send_sample(input word_t v, input bit known, input word_t kres);
		word_t     pred;
		filt_exp_t e;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		do @(posedge clk); while (!in_ready);
		pred = push_and_average(v);
		e.value = known ? kres : pred;
		e.seq   = items_sent;
		filt_q.push_back(e);
		items_sent++;
	endtask

	// The level is written only once the filter has drained and gone idle.
	task automatic program_level(input word_t lvl);
		in_valid <= 1'b0;
		while (filt_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we        <= 1'b1;
		initial_level <= lvl;
		@(posedge clk);
		cfg_we <= 1'b0;
		fill_model(lvl);
		levels_written++;
	endtask

	initial begin
		out_ready = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (filt_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("unexpected result: filtered=%0d", filtered);
				end
			end else begin
				head = filt_q.pop_front();
				if (filtered !== head.value) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("sample #%0d: filtered expected %0d, got %0d",
							head.seq, head.value, filtered);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("trimmed_mean_window_filter: mismatch");
			$finish;
		end
	end

	initial begin
		word_t        lvl;
		sample_mode_t mode;
		int           phase_len;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		initial_level  = '0;
		in_valid       = 1'b0;
		sample         = '0;
		quiet          = 1'b0;
		items_sent     = 0;
		levels_written = 0;
		results_seen   = 0;
		mismatches     = 0;
		stall_cycles   = 0;
		fill_model('0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[r]) begin
			if (dir_table[r].kind == ROW_LEVEL) begin
				program_level(dir_table[r].value);
			end else begin
				send_sample(dir_table[r].value, dir_table[r].known, dir_table[r].result);
			end
		end

		while (items_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 5))
				0: lvl = SAMPLE_MIN;
				1: lvl = SAMPLE_MAX;
				2: lvl = '0;
				default: lvl = word_t'($urandom_range(0, 16'hFFFF));
			endcase
			program_level(lvl);
			mode      = sample_mode_t'($urandom_range(0, 3));
			phase_len = $urandom_range(5, 40);
			for (int k = 0; k < phase_len && items_sent < ITEM_GOAL; k++) begin
				if (items_sent >= ITEM_GOAL - QUIET_TAIL) begin
					quiet = 1'b1;
				end
				send_sample(pick_sample(mode, lvl), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (filt_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (filt_q.size() != 0) begin
			mismatches++;
		end

		$display("%0d samples sent over %0d level writes, %0d filtered results checked",
			items_sent, levels_written, results_seen);
		$display("%0d mismatches found", mismatches);
		if (mismatches == 0) begin
			$display("trimmed_mean_window_filter: match");
		end else begin
			$display("trimmed_mean_window_filter: mismatch");
		end
		$finish;
	end

endmodule
